[src/assert_macros.svh]
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b in the same cycle
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// assert that a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[src/bsde_pkg.sv]
// package for the b-spline evaluator: types and constants
`default_nettype none
package bsde_pkg;
  localparam int MAX_POINTS = 64;
  localparam logic [1:0] ACT_POINT = 2'd0;
  localparam logic [1:0] ACT_KNOT  = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic       REG_ORDER = 1'b0;
  localparam logic       REG_COUNT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_LO, S_HI, S_CLAMP, S_SRCH_RD, S_SRCH, S_LOAD_RD, S_LOAD,
    S_KA, S_KB, S_DIV, S_DIVW, S_MX, S_MY, S_MZ, S_OUT
  } state_t;
endpackage
`default_nettype wire

[src/bsde_div.sv]
// iterative restoring divider for alpha, one quotient bit a cycle
`default_nettype none
module bsde_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 34
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic busy,
  output logic [NUM_W-1:0] quot
);
  import bsde_pkg::*;
  localparam int CW = $clog2(NUM_W + 1);
  logic [CW-1:0] cnt;
  logic [DEN_W:0] rem;
  logic [DEN_W:0] trial;
  logic [NUM_W-1:0] dnd;
  logic [DEN_W-1:0] dv;

  assign trial = {rem[DEN_W-1:0], dnd[NUM_W-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(NUM_W);
      rem <= '0;
      dnd <= num;
      dv <= den;
      quot <= '0;
    end else if (busy) begin
      dnd <= {dnd[NUM_W-2:0], 1'b0};
      if (!trial[DEN_W]) begin
        rem <= trial;
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-1:0], dnd[NUM_W-1]};
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[src/bspline_deboor_evaluate.sv]
// top level: control point and knot stores, sequencer and shared datapath
// Usage: one input channel (valid/ready) carries words of three kinds:
// control point writes, knot writes and evaluate requests. A write is
// taken without giving a result; writes can follow back to back.
// An evaluate gives one result word on the output channel (valid/ready)
// with x, y, z and a status code.
// An evaluate runs: two knot reads for the range, a clamp, a serial
// interval search that reads one knot per test, p+1 point reads, then
// p(p+1)/2 steps each of two knot reads, a 64-bit restoring division
// and three multiplies; the division is skipped when the knot interval
// is zero. With fewer than p+1 points it gives status ST_FEW and zeros.
// The block takes one word at a time and is not ready while busy. A
// result waits in its output register until taken; the next word is
// accepted only then. Reset clears the sequencer, sets order 3 and
// count 4; stores are undefined until written. Configuration is
// written through cfg_we/cfg_index/cfg_data.
`default_nettype none
module bspline_deboor_evaluate #(
  parameter int MAX_ORDER = 5,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [6:0] cfg_data,
  input  wire logic valid,
  output logic ready,
  input  wire logic [1:0] action,
  input  wire logic [6:0] entry_index,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic signed [31:0] knot_value,
  input  wire logic signed [31:0] eval_param,
  input  wire logic param_is_relative,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] curve_x,
  output logic signed [31:0] curve_y,
  output logic signed [31:0] curve_z,
  output logic [1:0] eval_status
);
  import bsde_pkg::*;
`include "assert_macros.svh"
  localparam int KD = MAX_POINTS + MAX_ORDER + 1;
  localparam int KW = $clog2(KD);
  localparam int PW = $clog2(MAX_POINTS);
  localparam int DW = MAX_ORDER + 1;
  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  logic [2:0] spline_order;
  logic [6:0] point_count;
  logic signed [31:0] kmem [KD];
  logic signed [31:0] xm [MAX_POINTS];
  logic signed [31:0] ym [MAX_POINTS];
  logic signed [31:0] zm [MAX_POINTS];
  logic [KW-1:0] kaddr;
  logic [PW-1:0] paddr;
  logic signed [31:0] kq, xq, yq, zq;
  logic signed [31:0] dx [DW];
  logic signed [31:0] dy [DW];
  logic signed [31:0] dz [DW];
  state_t state, state_next;
  logic [2:0] p, r, i;
  logic [6:0] cnt, k;
  logic signed [33:0] u, lo, hi, ka, alpha;
  logic [1:0] status;
  logic signed [33:0] den;
  logic signed [63:0] numer;
  logic div_start;
  logic div_busy;
  logic [63:0] dquot, dnum;
  logic [33:0] dden;
  logic neg;
  logic signed [32:0] diff;
  logic signed [66:0] prod;
  logic signed [32:0] sh;
  logic [2:0] pc;
  logic [6:0] cc;

  always_comb begin
    pc = spline_order;
    if (pc == 3'd0) pc = 3'd1;
    if (32'(pc) > MAX_ORDER) pc = 3'(MAX_ORDER);
    cc = point_count;
    if (32'(cc) > MAX_POINTS) cc = 7'(MAX_POINTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spline_order <= 3'd3;
      point_count <= 7'd4;
    end else if (cfg_we) begin
      if (cfg_index == REG_ORDER) spline_order <= cfg_data[2:0];
      else point_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready && action == ACT_POINT && 32'(entry_index) < MAX_POINTS) begin
      xm[PW'(entry_index)] <= point_x;
      ym[PW'(entry_index)] <= point_y;
      zm[PW'(entry_index)] <= point_z;
    end
    if (valid && ready && action == ACT_KNOT && 32'(entry_index) < KD)
      kmem[KW'(entry_index)] <= knot_value;
    kq <= kmem[kaddr];
    xq <= xm[paddr];
    yq <= ym[paddr];
    zq <= zm[paddr];
  end

  assign ready = (state == S_IDLE) && !out_valid;
  assign numer = 64'(u - ka) <<< FRAC_BITS;
  assign dnum = numer[63] ? 64'(-numer) : 64'(numer);
  assign den = 34'(kq) - ka;
  assign dden = den[33] ? 34'(-den) : 34'(den);

  bsde_div #(.NUM_W(64), .DEN_W(34)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .quot(dquot)
  );

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    kaddr = '0;
    paddr = PW'(32'(k) - 32'(p) + 32'(i));
    case (state)
      S_IDLE: begin
        kaddr = KW'(pc);
        if (valid && ready && action == ACT_EVAL) state_next = S_LO;
      end
      S_LO: begin
        kaddr = KW'(cnt);
        state_next = (cnt < 7'(p) + 7'd1) ? S_OUT : S_HI;
      end
      S_HI: state_next = S_CLAMP;
      S_CLAMP: state_next = S_SRCH_RD;
      S_SRCH_RD: begin kaddr = KW'(k + 7'd1); state_next = S_SRCH; end
      S_SRCH: begin
        kaddr = KW'(k + 7'd1);
        if (k < cnt - 7'd1 && 34'(kq) < u) state_next = S_SRCH_RD;
        else state_next = S_LOAD_RD;
      end
      S_LOAD_RD: state_next = S_LOAD;
      S_LOAD: state_next = (i == p) ? S_KA : S_LOAD_RD;
      S_KA: begin kaddr = KW'(7'(i) + k - 7'(p)); state_next = S_KB; end
      S_KB: begin kaddr = KW'(7'(i) + 7'd1 + k - 7'(r)); state_next = S_DIV; end
      S_DIV: begin
        if (den == '0) state_next = S_MX;
        else begin div_start = 1'b1; state_next = S_DIVW; end
      end
      S_DIVW: if (!div_busy && !div_start) state_next = S_MX;
      S_MX: state_next = S_MY;
      S_MY: state_next = S_MZ;
      S_MZ: state_next = (i == r && r == p) ? S_OUT : S_KA;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  logic signed [31:0] d0, d1;
  always_comb begin
    case (state)
      S_MY: begin d0 = dy[i-3'd1]; d1 = dy[i]; end
      S_MZ: begin d0 = dz[i-3'd1]; d1 = dz[i]; end
      default: begin d0 = dx[i-3'd1]; d1 = dx[i]; end
    endcase
    diff = 33'(d1) - 33'(d0);
    prod = 67'(alpha) * 67'(diff);
    sh = 33'(prod >>> FRAC_BITS);
  end

  logic signed [33:0] qs;
  always_comb begin
    qs = neg ? -$signed({1'b0, dquot[32:0]}) : $signed({1'b0, dquot[32:0]});
    if (|dquot[63:33]) qs = neg ? -ONE : ONE + 34'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == S_OUT) out_valid <= 1'b1;
    end
    case (state)
      S_IDLE: begin
        p <= pc; cnt <= cc; u <= 34'(eval_param); neg <= param_is_relative;
        status <= ST_OK; k <= 7'(pc); i <= '0; r <= 3'd1;
      end
      S_LO: begin
        lo <= 34'(kq);
        if (neg) u <= u + 34'(kq);
        if (cnt < 7'(p) + 7'd1) status <= ST_FEW;
      end
      S_HI: begin
        hi <= 34'(kq);
        if (u < lo) u <= lo;
      end
      S_CLAMP: if (u > hi) u <= hi;
      S_SRCH: if (k < cnt - 7'd1 && 34'(kq) < u) k <= k + 7'd1;
      S_LOAD: begin
        dx[i] <= xq; dy[i] <= yq; dz[i] <= zq;
        if (i == p) i <= p; else i <= i + 3'd1;
      end
      S_KB: ka <= 34'(kq);
      S_DIV: begin
        neg <= numer[63] ^ den[33];
        if (den == '0) begin alpha <= '0; status <= ST_ZERO; end
      end
      S_DIVW: if (!div_busy && !div_start) begin
        if (qs < 0) alpha <= '0;
        else if (qs > ONE) alpha <= ONE;
        else alpha <= qs;
      end
      S_MX: dx[i] <= 32'(33'(d0) + sh);
      S_MY: dy[i] <= 32'(33'(d0) + sh);
      S_MZ: begin
        dz[i] <= 32'(33'(d0) + sh);
        if (i == r) begin r <= r + 3'd1; i <= p; end else i <= i - 3'd1;
      end
      S_OUT: begin
        if (status == ST_FEW) begin
          curve_x <= '0; curve_y <= '0; curve_z <= '0;
        end else begin
          curve_x <= dx[p]; curve_y <= dy[p]; curve_z <= dz[p];
        end
        eval_status <= status;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, ready, state == S_IDLE)
  `ASSERT_NEXT(a_out_set, clk, rst, state == S_OUT, out_valid)
  `ASSERT_IMPL(a_div_idle, clk, rst, div_busy, state == S_DIVW)
endmodule
`default_nettype wire
